// ===== hdl/ecit_pkg.sv =====
package ecit_pkg;

   localparam int CHANNELS_DEFAULT      = 8;
   localparam int FAST_CHANNELS_DEFAULT = 4;
   localparam int COUNT_WIDTH_DEFAULT   = 16;

   localparam int ADDR_W   = 8;
   localparam int DATA_W   = 8;
   localparam int VEC_W    = 8;
   localparam int TARGET_W = 15;
   localparam int HOLD_W   = 15;
   localparam int CH_NUM_W = 3;
   localparam int CH_CMP_W = 5;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;

   localparam int SLOW_SCALE = 100;

   localparam logic [ADDR_W-1:0] LAST_SET_ADDR  = 8'h0F;
   localparam logic [ADDR_W-1:0] HOLD_BASE      = 8'h10;
   localparam logic [ADDR_W-1:0] LAST_HOLD_ADDR = 8'h17;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_WRITE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                expired;
      logic [HOLD_W-1:0]   left;
   } alu_result_type;

endpackage

// ===== hdl/ecit_alu.sv =====
module ecit_alu
   import ecit_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic [COUNT_WIDTH-1:0] count,
   input  logic [TARGET_W-1:0]    target,
   input  logic                   tick_mode,
   output logic [COUNT_WIDTH-1:0] count_inc,
   output alu_result_type         result
);

   logic [COUNT_WIDTH-1:0] operand;
   logic [COUNT_WIDTH-1:0] target_ext;
   logic                   reached;

   always_comb begin
      count_inc  = (count == '1) ? count : count + COUNT_WIDTH'(1);
      operand    = tick_mode ? count_inc : count;
      target_ext = COUNT_WIDTH'(target);
      reached    = operand >= target_ext;
      result.expired = reached && (target != '0);
      result.left    = reached ? '0 : HOLD_W'(target - operand[TARGET_W-1:0]);
   end

endmodule

// ===== hdl/eight_channel_interval_timer_core.sv =====
// Interval timer with CHANNELS channels, each holding a target period, an
// interrupt vector and a saturating elapsed count. A request is either a
// tick (req_tuser = 0) or a bus write (req_tuser = 1) and always yields one
// response. Even addresses 0x00-0x0E load a target (value for channels below
// FAST_CHANNELS, value*100 for the rest), odd addresses load a vector, and
// both restart the channel; 0x10-0x17 return the ticks left on that channel.
// A tick advances every count and restarts expired channels from channel 0
// up to the first expired channel with a nonzero vector, which raises the
// interrupt; expired channels after it only advance. One count/compare/
// subtract unit visits one channel per cycle, through all channels in ST_TICK
// for a tick or the addressed one in ST_WRITE. A finished response waits in
// an output register while the next request is taken.
module eight_channel_interval_timer_core
   import ecit_pkg::*;
#(
   parameter int CHANNELS      = CHANNELS_DEFAULT,
   parameter int FAST_CHANNELS = FAST_CHANNELS_DEFAULT,
   parameter int COUNT_WIDTH   = COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // address[7:0], value[15:8]
   input  logic                   req_tuser,   // opcode[0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // irq_vector[7:0], hold_ticks[22:8], zero[23]
   output logic                   rsp_tuser    // irq_valid[0]
);

   localparam int IDX_W = $clog2(CHANNELS);

   state_type state_ff, state_in;

   logic [IDX_W-1:0]       scan_idx_ff, scan_idx_in;
   logic                   op_ff;
   logic [ADDR_W-1:0]      addr_ff;
   logic [DATA_W-1:0]      val_ff;

   logic [COUNT_WIDTH-1:0] count_ff  [CHANNELS];
   logic [TARGET_W-1:0]    target_ff [CHANNELS];
   logic [VEC_W-1:0]       vector_ff [CHANNELS];

   logic                   fired_ff;
   logic [VEC_W-1:0]       res_vec_ff;
   logic [HOLD_W-1:0]      res_hold_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_irq_ff;
   logic [VEC_W-1:0]       rsp_vec_ff;
   logic [HOLD_W-1:0]      rsp_hold_ff;

   logic                   req_fire;
   logic                   step_tick;
   logic                   step_write;
   logic                   finish_load;
   logic                   scan_last;
   logic                   slot_free;

   logic [CH_NUM_W-1:0]    ch_num;
   logic                   ch_exists;
   logic                   is_set;
   logic                   is_hold;
   logic                   ch_fast;
   logic [IDX_W-1:0]       sel_idx;
   logic [TARGET_W-1:0]    set_target;

   logic [COUNT_WIDTH-1:0] count_inc;
   alu_result_type         alu_res;

   always_comb begin
      is_set    = addr_ff <= LAST_SET_ADDR;
      is_hold   = !is_set && (addr_ff <= LAST_HOLD_ADDR);
      ch_num    = is_set ? addr_ff[CH_NUM_W:1] : CH_NUM_W'(addr_ff - HOLD_BASE);
      ch_exists = CH_CMP_W'(ch_num) < CH_CMP_W'(CHANNELS);
      ch_fast   = CH_CMP_W'(ch_num) < CH_CMP_W'(FAST_CHANNELS);
      sel_idx   = (state_ff == ST_TICK) ? scan_idx_ff : IDX_W'(ch_num);
      scan_last = scan_idx_ff == IDX_W'(CHANNELS - 1);
      slot_free = !rsp_valid_ff || rsp_tready;
      set_target = ch_fast ? TARGET_W'(val_ff)
                           : TARGET_W'({7'd0, val_ff} * TARGET_W'(SLOW_SCALE));
   end

   ecit_alu #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_alu (
      .count     (count_ff[sel_idx]),
      .target    (target_ff[sel_idx]),
      .tick_mode (state_ff == ST_TICK),
      .count_inc (count_inc),
      .result    (alu_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_tuser == OP_TICK) ? ST_TICK : ST_WRITE;
            end
         end
         ST_TICK: begin
            if (scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_WRITE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_tready  = 1'b0;
      step_tick   = 1'b0;
      step_write  = 1'b0;
      finish_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_TICK: begin
            step_tick = 1'b1;
         end
         ST_WRITE: begin
            step_write = 1'b1;
         end
         ST_FINISH: begin
            finish_load = slot_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign req_fire    = req_tvalid && req_tready;
   assign scan_idx_in = step_tick ? scan_idx_ff + IDX_W'(1) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_idx_ff  <= '0;
         fired_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            count_ff[i]  <= '0;
            target_ff[i] <= '0;
            vector_ff[i] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         scan_idx_ff <= scan_idx_in;

         if (req_fire) begin
            fired_ff <= 1'b0;
         end

         // advance and restart one channel per cycle
         if (step_tick) begin
            if (alu_res.expired && !fired_ff) begin
               count_ff[sel_idx] <= '0;
               if (vector_ff[sel_idx] != '0) begin
                  fired_ff <= 1'b1;
               end
            end else begin
               count_ff[sel_idx] <= count_inc;
            end
         end

         if (step_write && is_set && ch_exists) begin
            if (addr_ff[0] == 1'b0) begin
               target_ff[sel_idx] <= set_target;
            end else begin
               vector_ff[sel_idx] <= val_ff;
            end
            count_ff[sel_idx] <= '0;
         end

         if (finish_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff       <= req_tuser;
         addr_ff     <= req_tdata[ADDR_W-1:0];
         val_ff      <= req_tdata[ADDR_W +: DATA_W];
         res_vec_ff  <= '0;
         res_hold_ff <= '0;
      end
      if (step_tick && alu_res.expired && !fired_ff && (vector_ff[sel_idx] != '0)) begin
         res_vec_ff <= vector_ff[sel_idx];
      end
      if (step_write && is_hold && ch_exists) begin
         res_hold_ff <= alu_res.left;
      end
      if (finish_load) begin
         rsp_irq_ff  <= (op_ff == OP_TICK) && fired_ff;
         rsp_vec_ff  <= res_vec_ff;
         rsp_hold_ff <= res_hold_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_irq_ff;
   assign rsp_tdata  = {1'b0, rsp_hold_ff, rsp_vec_ff};

endmodule

// ===== verif/interval_timer_checker.sv =====
module interval_timer_checker
   import ecit_pkg::*;
#(
   parameter int CHANNELS      = CHANNELS_DEFAULT,
   parameter int FAST_CHANNELS = FAST_CHANNELS_DEFAULT,
   parameter int COUNT_WIDTH   = COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // address[7:0], value[15:8]
   input  logic                   req_tuser,   // opcode[0]
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,   // irq_vector[7:0], hold_ticks[22:8], zero[23]
   input  logic                   rsp_tuser,   // irq_valid[0]
   output int                     mismatch_count,
   output int                     pending_count
);

   typedef struct packed {
      logic              irq_valid;
      logic [VEC_W-1:0]  irq_vector;
      logic [HOLD_W-1:0] hold_ticks;
   } timer_result_type;

   logic [COUNT_WIDTH-1:0] elapsed_ticks  [CHANNELS];
   logic [TARGET_W-1:0]    period_ticks   [CHANNELS];
   logic [VEC_W-1:0]       channel_vector [CHANNELS];
   timer_result_type       due_results    [$];
   int                     fault_total = 0;

   function automatic timer_result_type step_timer(input logic opcode,
                                                   input logic [ADDR_W-1:0] address,
                                                   input logic [DATA_W-1:0] value);
      timer_result_type res;
      int               ch;
      logic             fired;
      res   = '0;
      fired = 1'b0;
      if (opcode == OP_TICK) begin
         for (ch = 0; ch < CHANNELS; ch++) begin
            if (elapsed_ticks[ch] != '1) begin
               elapsed_ticks[ch] = elapsed_ticks[ch] + 1'b1;
            end
         end
         for (ch = 0; ch < CHANNELS; ch++) begin
            if (!fired && period_ticks[ch] != '0 && elapsed_ticks[ch] >= period_ticks[ch]) begin
               elapsed_ticks[ch] = '0;
               if (channel_vector[ch] != '0) begin
                  res.irq_valid  = 1'b1;
                  res.irq_vector = channel_vector[ch];
                  fired          = 1'b1;
               end
            end
         end
      end else if (address <= LAST_SET_ADDR) begin
         ch = int'(address >> 1);
         if (ch < CHANNELS) begin
            if (!address[0]) begin
               if (ch < FAST_CHANNELS) begin
                  period_ticks[ch] = TARGET_W'(value);
               end else begin
                  period_ticks[ch] = TARGET_W'(int'(value) * SLOW_SCALE);
               end
            end else begin
               channel_vector[ch] = value;
            end
            elapsed_ticks[ch] = '0;
         end
      end else if (address <= LAST_HOLD_ADDR) begin
         ch = int'(address - HOLD_BASE);
         if (ch < CHANNELS && elapsed_ticks[ch] < period_ticks[ch]) begin
            res.hold_ticks = HOLD_W'(period_ticks[ch] - elapsed_ticks[ch]);
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      timer_result_type want;
      if (reset) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            elapsed_ticks[ch]  = '0;
            period_ticks[ch]   = '0;
            channel_vector[ch] = '0;
         end
         due_results.delete();
         pending_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               fault_total++;
               if (fault_total <= 10) begin
                  $display("unexpected response: irq_valid=%0d tdata=%h", rsp_tuser, rsp_tdata);
               end
            end else begin
               want = due_results.pop_front();
               if (rsp_tuser !== want.irq_valid
                   || rsp_tdata[VEC_W-1:0] !== want.irq_vector
                   || rsp_tdata[VEC_W +: HOLD_W] !== want.hold_ticks
                   || rsp_tdata[RSP_TDATA_W-1] !== 1'b0) begin
                  fault_total++;
                  if (fault_total <= 10) begin
                     $display({"response mismatch: expected irq_valid=%0d irq_vector=%h",
                               " hold_ticks=%0d pad=0, got irq_valid=%0d irq_vector=%h",
                               " hold_ticks=%0d pad=%0d"},
                              want.irq_valid, want.irq_vector, want.hold_ticks,
                              rsp_tuser, rsp_tdata[VEC_W-1:0], rsp_tdata[VEC_W +: HOLD_W],
                              rsp_tdata[RSP_TDATA_W-1]);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            due_results.push_back(step_timer(req_tuser, req_tdata[ADDR_W-1:0],
                                             req_tdata[ADDR_W +: DATA_W]));
         end
         pending_count <= due_results.size();
      end
      mismatch_count <= fault_total;
   end

endmodule

// ===== verif/tb_eight_channel_interval_timer_core.sv =====
module tb_eight_channel_interval_timer_core;
   import ecit_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int RANDOM_ITEMS   = 1050;
   localparam int HOLD_OFF_START = 300;
   localparam int HOLD_OFF_LEN   = 600;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = OP_TICK;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;

   int   mismatch_count;
   int   pending_count;
   int   cycle_count = 0;
   int   sent_total = 0;
   int   rsp_gap = 0;
   logic idle_on = 1'b1;
   logic rsp_hold_off = 1'b0;

   eight_channel_interval_timer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   interval_timer_checker timer_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_eight_channel_interval_timer_core: errors");
         $finish;
      end
   end

   function automatic int draw_gap();
      return idle_on ? int'($urandom_range(0, 14)) : 0;
   endfunction

   function automatic logic [ADDR_W-1:0] target_addr(input int ch);
      return ADDR_W'(2 * ch);
   endfunction

   function automatic logic [ADDR_W-1:0] vector_addr(input int ch);
      return ADDR_W'(2 * ch + 1);
   endfunction

   function automatic logic [ADDR_W-1:0] hold_addr(input int ch);
      return HOLD_BASE + ADDR_W'(ch);
   endfunction

   always @(posedge clock) begin : rsp_side
      int next_gap;
      if (reset) begin
         rsp_gap    <= 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            next_gap = draw_gap();
         end else begin
            next_gap = (rsp_gap > 0) ? rsp_gap - 1 : 0;
         end
         rsp_gap    <= next_gap;
         rsp_tready <= (next_gap == 0) && !rsp_hold_off;
      end
   end

   // hold the response side off long enough to back up the request side
   initial begin
      while (sent_total < HOLD_OFF_START) @(posedge clock);
      rsp_hold_off <= 1'b1;
      repeat (HOLD_OFF_LEN) @(posedge clock);
      rsp_hold_off <= 1'b0;
   end

   task automatic offer_request(input logic opcode, input logic [ADDR_W-1:0] address,
                                input logic [DATA_W-1:0] value);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= opcode;
      req_tdata  <= {value, address};
      do @(posedge clock); while (!req_tready);
      sent_total++;
   endtask

   task automatic pick_request(output logic opcode, output logic [ADDR_W-1:0] address,
                               output logic [DATA_W-1:0] value);
      int roll;
      int ch;
      roll    = $urandom_range(0, 99);
      ch      = $urandom_range(0, 7);
      opcode  = OP_WRITE;
      address = ADDR_W'($urandom_range(0, 255));
      value   = DATA_W'($urandom_range(0, 255));
      if (roll < 50) begin
         opcode = OP_TICK;
      end else if (roll < 70) begin
         address = target_addr(ch);
         if (ch < FAST_CHANNELS_DEFAULT) begin
            if ($urandom_range(0, 3) != 0) value = DATA_W'($urandom_range(1, 12));
         end else begin
            if ($urandom_range(0, 7) != 0) value = DATA_W'($urandom_range(0, 1));
         end
      end else if (roll < 82) begin
         address = vector_addr(ch);
         if ($urandom_range(0, 3) == 0) value = '0;
      end else if (roll < 94) begin
         address = hold_addr(ch);
      end else begin
         address = ADDR_W'($urandom_range(int'(LAST_HOLD_ADDR) + 1, 255));
      end
   endtask

   initial begin : stimulus
      logic              opcode;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] value;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      offer_request(OP_WRITE, hold_addr(0), '0);
      offer_request(OP_TICK, '1, '1);
      offer_request(OP_WRITE, target_addr(0), 8'd3);
      offer_request(OP_WRITE, vector_addr(0), 8'hA5);
      offer_request(OP_WRITE, target_addr(1), 8'd2);
      offer_request(OP_WRITE, vector_addr(1), '0);
      offer_request(OP_WRITE, target_addr(7), '1);
      offer_request(OP_WRITE, vector_addr(7), '1);
      offer_request(OP_WRITE, target_addr(6), '0);
      offer_request(OP_WRITE, vector_addr(6), 8'h80);
      offer_request(OP_WRITE, LAST_HOLD_ADDR, '0);
      offer_request(OP_TICK, '0, '0);
      offer_request(OP_WRITE, hold_addr(0), '0);
      offer_request(OP_TICK, '0, '0);
      offer_request(OP_TICK, '0, '0);
      offer_request(OP_WRITE, target_addr(4), 8'd1);
      offer_request(OP_WRITE, target_addr(3), '1);
      offer_request(OP_WRITE, vector_addr(3), 8'h01);
      offer_request(OP_WRITE, hold_addr(6), '0);
      offer_request(OP_WRITE, hold_addr(3), 8'h5A);
      offer_request(OP_WRITE, LAST_HOLD_ADDR + 1'b1, '1);
      offer_request(OP_WRITE, '1, '0);
      offer_request(OP_WRITE, hold_addr(1), 8'h5A);
      repeat (3) offer_request(OP_TICK, '0, '0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 120 == 0) idle_on <= ($urandom_range(0, 2) != 0);
         pick_request(opcode, address, value);
         offer_request(opcode, address, value);
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_eight_channel_interval_timer_core: clean");
      end else begin
         $display("tb_eight_channel_interval_timer_core: errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/ecit_pkg.sv
hdl/ecit_alu.sv
hdl/eight_channel_interval_timer_core.sv
verif/interval_timer_checker.sv
verif/tb_eight_channel_interval_timer_core.sv
